// ----- hdl/fsd_pkg.sv -----
// fsd_pkg: shared types, constants and helpers of the Floyd-Steinberg 1-bit dither
// used by every module under hdl/; depends on nothing
package fsd_pkg;

    localparam int C_MAX_WIDTH = 1024;
    localparam int GRAY_W      = 8;
    localparam int ERR_W       = 8;
    localparam int CARRY_W     = 7;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int BITPOS_W    = 3;
    localparam int PROD_W      = 11;

    localparam logic [CFG_WIDTH_W-1:0]  C_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] C_HEIGHT_RESET = 16'd1;
    localparam logic [GRAY_W-1:0]       C_WHITE        = 8'd255;
    localparam logic [GRAY_W-1:0]       C_MSB          = 8'h80;
    localparam logic [BITPOS_W-1:0]     C_LAST_BIT     = 3'd7;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // per-pixel control handed from the front end to the diffusion stage
    typedef struct packed {
        logic                first_col;
        logic                first_row;
        logic                last_col;
        logic                last_row;
        logic                emit;
        logic [BITPOS_W-1:0] bit_pos;
    } t_pix_ctl;

    // signed divide by 16, truncating toward zero
    function automatic logic signed [ERR_W-1:0] f_div16(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [ERR_W-1:0]  q;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        q   = ERR_W'(mag >> 4);
        return p[PROD_W-1] ? ERR_W'(-q) : q;
    endfunction

endpackage

// ----- hdl/fsd_line_mem.sv -----
// fsd_line_mem: error line store, one write and one registered read port
// depends on fsd_pkg
module fsd_line_mem #(
    parameter int MAX_WIDTH = fsd_pkg::C_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_waddr,
    input  logic [fsd_pkg::ERR_W-1:0]       i_wdata,
    input  logic                            i_re,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_raddr,
    output logic [fsd_pkg::ERR_W-1:0]       o_rdata
);
    import fsd_pkg::*;

    logic [ERR_W-1:0] r_mem [MAX_WIDTH];
    logic [ERR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fsd_diffuse.sv -----
// fsd_diffuse: threshold, error split and bit packing for one pixel per cycle while i_commit is high
// depends on fsd_pkg
module fsd_diffuse #(
    parameter int MAX_WIDTH = fsd_pkg::C_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_commit,
    input  logic [fsd_pkg::GRAY_W-1:0]          i_gray,
    input  logic signed [fsd_pkg::ERR_W-1:0]    i_below,
    input  fsd_pkg::t_pix_ctl                   i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_x,
    output logic                                o_pix_we,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_pix_addr,
    output logic [fsd_pkg::ERR_W-1:0]           o_pix_data,
    output logic                                o_tail_we,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_tail_addr,
    output logic [fsd_pkg::ERR_W-1:0]           o_tail_data,
    output logic [fsd_pkg::GRAY_W-1:0]          o_byte
);
    import fsd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int VW = GRAY_W + 2;

    logic signed [CARRY_W-1:0] r_carry, n_carry;
    logic signed [ERR_W-1:0]   r_pend_left, n_pend_left;
    logic signed [ERR_W-1:0]   r_pend_center, n_pend_center;
    logic [GRAY_W-1:0]         r_acc, n_acc;

    logic signed [VW-1:0]      v;
    logic [GRAY_W-1:0]         vc;
    logic                      white;
    logic [GRAY_W:0]           err9;
    logic signed [PROD_W-1:0]  e11;
    logic signed [ERR_W-1:0]   d7, d3, d5, d1;
    logic [GRAY_W-1:0]         acc_bits;

    always_comb begin
        v = $signed({2'b00, i_gray}) + $signed({{2{i_below[ERR_W-1]}}, i_below});
        if (!i_ctl.first_col) begin
            v = v + $signed({{(VW-CARRY_W){r_carry[CARRY_W-1]}}, r_carry});
        end
        if (v < 0) begin
            vc = '0;
        end else if (v > $signed({2'b00, C_WHITE})) begin
            vc = C_WHITE;
        end else begin
            vc = v[GRAY_W-1:0];
        end
        white = vc[GRAY_W-1];
        err9  = {1'b0, vc} - (white ? {1'b0, C_WHITE} : '0);
        e11   = $signed({{(PROD_W-ERR_W){err9[ERR_W-1]}}, err9[ERR_W-1:0]});
        d7    = f_div16((e11 <<< 3) - e11);
        d3    = f_div16((e11 <<< 1) + e11);
        d5    = f_div16((e11 <<< 2) + e11);
        d1    = f_div16(e11);

        n_carry       = i_ctl.last_col ? '0 : d7[CARRY_W-1:0];
        n_pend_left   = r_pend_left;
        n_pend_center = r_pend_center;
        if (!i_ctl.last_row) begin
            n_pend_left   = r_pend_center + d5;
            n_pend_center = i_ctl.last_col ? '0 : d1;
        end
        o_pix_we    = i_commit && !i_ctl.last_row && !i_ctl.first_col;
        o_pix_addr  = i_x - AW'(1);
        o_pix_data  = r_pend_left + d3;
        o_tail_we   = i_commit && !i_ctl.last_row && i_ctl.last_col;
        o_tail_addr = i_x;
        o_tail_data = n_pend_left;
        if (i_ctl.last_col) begin
            n_pend_left   = '0;
            n_pend_center = '0;
        end

        acc_bits = white ? (C_MSB >> i_ctl.bit_pos) : '0;
        o_byte   = r_acc | acc_bits;
        n_acc    = i_ctl.emit ? '0 : o_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry       <= '0;
            r_pend_left   <= '0;
            r_pend_center <= '0;
            r_acc         <= '0;
        end else if (i_commit) begin
            r_carry       <= n_carry;
            r_pend_left   <= n_pend_left;
            r_pend_center <= n_pend_center;
            r_acc         <= n_acc;
        end
    end

endmodule

// ----- hdl/floyd_steinberg_dither_1bit.sv -----
// floyd_steinberg_dither_1bit: top level of the 8-bit gray to 1-bit dither
// depends on fsd_pkg, fsd_line_mem and fsd_diffuse
//
// Usage
//   s_axis carries one 8-bit gray pixel per request in raster order.
//   m_axis carries one packed byte per request, leftmost pixel in bit 7,
//   after every eight pixels and at each row end; tlast marks the last byte
//   of a row and tuser the last byte of the image.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle: index 0 is the image width, index 1 the image height.
//   One pixel is taken every clock unless a stalled m_axis holds s_axis_tready
//   low. An accepted pixel waits in the diffusion stage register until it
//   commits, and its byte then passes through the output register to m_axis.
//   The error line lives in a one-read, one-write RAM read at accept time;
//   writes that land on the entry being read are forwarded.
//   Reset clears counters, carried errors and the output valid flag; the
//   line RAM needs no clearing pass since the first row ignores what it reads.
//   When m_axis stalls, the output register holds its byte; pixels keep
//   entering until the one that closes the next byte reaches the diffusion
//   stage, and s_axis_tready stays low while that pixel waits on the full
//   output register.
module floyd_steinberg_dither_1bit #(
    parameter int MAX_WIDTH = fsd_pkg::C_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] gray
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
    output logic                                m_axis_tlast,   // row_end
    output logic                                m_axis_tuser,   // [0] image_end
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_idx,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fsd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic [CW-1:0]           eff_w;
    logic [CFG_HEIGHT_W-1:0] eff_h;

    logic [AW-1:0]           r_col, n_col;
    logic [CFG_HEIGHT_W-1:0] r_row, n_row;
    logic [BITPOS_W-1:0]     r_bits, n_bits;
    logic [AW:0]             col_inc;
    logic [CFG_HEIGHT_W:0]   row_inc;
    t_pix_ctl                ctl_in;

    logic                    accept;
    logic                    r_s1_valid;
    logic [GRAY_W-1:0]       r_s1_gray;
    logic [AW-1:0]           r_s1_x;
    t_pix_ctl                r_s1_ctl;
    logic                    s1_done;

    logic                    r_fwd_hit, n_fwd_hit;
    logic [ERR_W-1:0]        r_fwd_data, n_fwd_data;
    logic [ERR_W-1:0]        mem_rdata;
    logic signed [ERR_W-1:0] below;

    logic                    pix_we, tail_we;
    logic [AW-1:0]           pix_addr, tail_addr;
    logic [ERR_W-1:0]        pix_data, tail_data;
    logic [GRAY_W-1:0]       s1_byte;

    logic                    r_tail_valid;
    logic [AW-1:0]           r_tail_addr;
    logic [ERR_W-1:0]        r_tail_data;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [ERR_W-1:0]        mem_wdata;

    logic                    r_out_valid;
    logic [GRAY_W-1:0]       r_out_byte;
    logic                    r_out_row_end;
    logic                    r_out_img_end;
    logic                    out_load;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= C_WIDTH_RESET;
            r_height <= C_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            eff_w = CW'(1);
        end else if (r_width > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(r_width);
        end
        eff_h = (r_height == '0) ? CFG_HEIGHT_W'(1) : r_height;
    end

    // front end: position counters and line read at accept
    assign s1_done       = r_s1_valid && (!r_s1_ctl.emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col_inc          = (AW+1)'(r_col) + (AW+1)'(1);
        row_inc          = (CFG_HEIGHT_W+1)'(r_row) + (CFG_HEIGHT_W+1)'(1);
        ctl_in.first_col = (r_col == '0);
        ctl_in.first_row = (r_row == '0);
        ctl_in.last_col  = (col_inc >= eff_w);
        ctl_in.last_row  = (row_inc >= eff_h);
        ctl_in.emit      = (r_bits == C_LAST_BIT) || ctl_in.last_col;
        ctl_in.bit_pos   = r_bits;
        n_col            = r_col;
        n_row            = r_row;
        n_bits           = r_bits;
        if (accept) begin
            if (ctl_in.last_col) begin
                n_col = '0;
                n_row = ctl_in.last_row ? '0 : row_inc[CFG_HEIGHT_W-1:0];
            end else begin
                n_col = col_inc[AW-1:0];
            end
            n_bits = ctl_in.emit ? '0 : r_bits + BITPOS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bits <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bits <= n_bits;
        end
    end

    // forwarding of line writes that land on the entry read at this edge
    always_comb begin
        n_fwd_hit  = 1'b0;
        n_fwd_data = r_tail_data;
        if (tail_we && tail_addr == r_col) begin
            n_fwd_hit  = 1'b1;
            n_fwd_data = tail_data;
        end else if (pix_we && pix_addr == r_col) begin
            n_fwd_hit  = 1'b1;
            n_fwd_data = pix_data;
        end else if (r_tail_valid && r_tail_addr == r_col) begin
            n_fwd_hit  = 1'b1;
            n_fwd_data = r_tail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_gray  <= s_axis_tdata;
            r_s1_x     <= r_col;
            r_s1_ctl   <= ctl_in;
            r_fwd_hit  <= n_fwd_hit;
            r_fwd_data <= n_fwd_data;
        end
    end

    assign below = r_s1_ctl.first_row ? '0 :
                   $signed(r_fwd_hit ? r_fwd_data : mem_rdata);

    fsd_diffuse #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_diffuse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (s1_done),
        .i_gray      (r_s1_gray),
        .i_below     (below),
        .i_ctl       (r_s1_ctl),
        .i_x         (r_s1_x),
        .o_pix_we    (pix_we),
        .o_pix_addr  (pix_addr),
        .o_pix_data  (pix_data),
        .o_tail_we   (tail_we),
        .o_tail_addr (tail_addr),
        .o_tail_data (tail_data),
        .o_byte      (s1_byte)
    );

    // row-end entry waits in r_tail until a cycle with no pixel write frees the port
    always_comb begin
        mem_we    = pix_we || r_tail_valid;
        mem_waddr = pix_we ? pix_addr : r_tail_addr;
        mem_wdata = pix_we ? pix_data : r_tail_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_valid <= 1'b0;
        end else if (tail_we) begin
            r_tail_valid <= 1'b1;
        end else if (!pix_we) begin
            r_tail_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_we) begin
            r_tail_addr <= tail_addr;
            r_tail_data <= tail_data;
        end
    end

    fsd_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (mem_rdata)
    );

    // output register
    assign out_load = s1_done && r_s1_ctl.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte    <= s1_byte;
            r_out_row_end <= r_s1_ctl.last_col;
            r_out_img_end <= r_s1_ctl.last_col && r_s1_ctl.last_row;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_row_end;
    assign m_axis_tuser  = r_out_img_end;

endmodule

// ----- hdl/fsd_checker.sv -----
// fsd_checker: port-level checks on the dither top level, bound to it below
// depends on fsd_pkg and floyd_steinberg_dither_1bit
module fsd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic                            m_axis_tuser
);
    import fsd_pkg::*;

    // image end only on a row end
    a_img_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast || !m_axis_tuser))
        else $error("image end without row end");

    // an empty output register never stalls the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output empty");

    // held request keeps valid
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output request dropped");

    // held request keeps its payload
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
        else $error("output payload changed while stalled");

endmodule

bind floyd_steinberg_dither_1bit fsd_checker u_fsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/floyd_steinberg_dither_1bit_tb.sv -----
// floyd_steinberg_dither_1bit_tb: self-checking bench for the 1-bit error diffusion dither
// predicts each packed byte from the accepted gray pixels and compares it on m_axis
// depends on fsd_pkg and floyd_steinberg_dither_1bit
`timescale 1ns / 1ps

module floyd_steinberg_dither_1bit_tb;
    import fsd_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] bits;
        logic       row_end;
        logic       image_end;
    } t_dith_byte;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    logic [0:0]            i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic [7:0]  gray_backlog[$];
    t_dith_byte  bytes_due[$];
    int          mismatch_cnt  = 0;
    int          send_gap_pct  = 0;
    int          recv_stall_pct = 0;
    int          bytes_seen    = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    int          quiet_cycles  = 0;

    // shadow of the dither state
    logic [CFG_WIDTH_W-1:0]  shadow_w = C_WIDTH_RESET;
    logic [CFG_HEIGHT_W-1:0] shadow_h = C_HEIGHT_RESET;
    int          err_line[C_MAX_WIDTH];
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;
    int          carry_right = 0;
    int          pend_bl = 0;
    int          pend_bc = 0;
    logic [7:0]  acc_bits = '0;
    int unsigned bit_cnt = 0;

    floyd_steinberg_dither_1bit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void dither_pixel(input logic [7:0] gray);
        int unsigned wv, hv, x, y;
        bit          last_col, last_row, white;
        int          v, err;
        t_dith_byte  b;
        wv = (shadow_w == 0) ? 1 : ((shadow_w > C_MAX_WIDTH) ? C_MAX_WIDTH : shadow_w);
        hv = (shadow_h == 0) ? 1 : shadow_h;
        x = col_cnt;
        y = row_cnt;
        last_col = (x + 1 >= wv);
        last_row = (y + 1 >= hv);
        v = gray;
        if (y > 0 && x < C_MAX_WIDTH) v += err_line[x];
        if (x > 0) v += carry_right;
        if (v < 0) v = 0;
        if (v > C_WHITE) v = C_WHITE;
        white = (v >= 128);
        err = v - (white ? int'(C_WHITE) : 0);
        carry_right = last_col ? 0 : err * 7 / 16;
        if (!last_row) begin
            if (x > 0 && x - 1 < C_MAX_WIDTH) err_line[x - 1] = pend_bl + err * 3 / 16;
            pend_bl = pend_bc + err * 5 / 16;
            pend_bc = last_col ? 0 : err / 16;
            if (last_col && x < C_MAX_WIDTH) err_line[x] = pend_bl;
        end
        if (last_col) begin
            pend_bl = 0;
            pend_bc = 0;
        end
        if (white) acc_bits |= C_MSB >> bit_cnt;
        if (bit_cnt >= C_LAST_BIT || last_col) begin
            b.bits      = acc_bits;
            b.row_end   = last_col;
            b.image_end = last_col && last_row;
            bytes_due.push_back(b);
            acc_bits = '0;
            bit_cnt  = 0;
            if (last_col) begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : ((y + 1) & 32'hFFFF);
            end else begin
                col_cnt = (x + 1) & 32'h7FF;
            end
        end else begin
            bit_cnt = bit_cnt + 1;
            col_cnt = (x + 1) & 32'h7FF;
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // pixel request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) dither_pixel(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gray_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= gray_backlog.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // byte monitor with random and long stalls
    always @(posedge i_clk) begin
        t_dith_byte want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                bytes_seen++;
                if (bytes_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %h", m_axis_tdata));
                end else begin
                    want = bytes_due.pop_front();
                    if (m_axis_tdata !== want.bits)
                        flag_mismatch($sformatf("byte %0d bits %h, want %h",
                                                bytes_seen, m_axis_tdata, want.bits));
                    if (m_axis_tlast !== want.row_end)
                        flag_mismatch($sformatf("byte %0d row_end %b, want %b",
                                                bytes_seen, m_axis_tlast, want.row_end));
                    if (m_axis_tuser !== want.image_end)
                        flag_mismatch($sformatf("byte %0d image_end %b, want %b",
                                                bytes_seen, m_axis_tuser, want.image_end));
                end
            end
            if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && gray_backlog.size() >= 32) begin
                hold_done     <= 1'b1;
                hold_left     <= 80;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) shadow_w = val[CFG_WIDTH_W-1:0];
        else shadow_h = val;
    endtask

    task automatic drain();
        while (gray_backlog.size() != 0 || s_axis_tvalid || bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idle(input int mode);
        send_gap_pct   = (mode == 1) ? 62 : ((mode == 3) ? 27 : 0);
        recv_stall_pct = (mode == 2) ? 62 : ((mode == 3) ? 27 : 0);
    endtask

    task automatic push_pixels(input int n, input int style);
        for (int i = 0; i < n; i++) begin
            case (style)
                0: gray_backlog.push_back(8'($urandom_range(255)));
                1: gray_backlog.push_back(8'($urandom_range(118, 138)));
                2: gray_backlog.push_back($urandom_range(1) ? 8'd255 : 8'd0);
                default: gray_backlog.push_back(8'(i * 13 + $urandom_range(7)));
            endcase
        end
    endtask

    // lower the width in the middle of the first row of an image
    task automatic cut_row(input int w_start, input int cut_at, input int w_end, input int rows);
        write_reg(CFG_IMAGE_WIDTH, 16'(w_start));
        write_reg(CFG_IMAGE_HEIGHT, 16'(rows));
        push_pixels(cut_at, 0);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'(w_end));
        push_pixels(((cut_at >= w_end) ? 1 : w_end - cut_at) + (rows - 1) * w_end, 3);
        drain();
    endtask

    initial begin
        int w, h, ew, eh, n_img, rand_px, grp;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // width zero and height zero: every pixel is its own image
        set_idle(0);
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        gray_backlog = '{8'd0, 8'd255, 8'd128, 8'd127};
        drain();

        // small image with extremes, threshold neighbors and clamping
        write_reg(CFG_IMAGE_WIDTH, 16'd5);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        gray_backlog = '{8'd255, 8'd0, 8'd128, 8'd127, 8'd200,
                         8'd0, 8'd255, 8'd60, 8'd190, 8'd127,
                         8'd128, 8'd128, 8'd0, 8'd255, 8'd1};
        drain();

        // width above the maximum cut short, long receiver hold
        cut_row(2047, 40, 30, 2);

        // tallest image, cut short by lowering the height
        set_idle(1);
        write_reg(CFG_IMAGE_WIDTH, 16'd6);
        write_reg(CFG_IMAGE_HEIGHT, 16'd65535);
        push_pixels(18, 0);
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        push_pixels(6, 0);
        drain();

        set_idle(2);
        cut_row(1024, 16, 20, 3);
        set_idle(3);
        cut_row(1024, 16, 10, 2);

        rand_px = 0;
        grp = 0;
        while (rand_px < 250) begin
            if ($urandom_range(9) == 0) w = 0;
            else if ($urandom_range(5) == 0) w = $urandom_range(25, 70);
            else w = $urandom_range(1, 24);
            h = $urandom_range(0, 4);
            ew = (w == 0) ? 1 : w;
            if (ew * ((h == 0) ? 1 : h) > 150) h = 1;
            eh = (h == 0) ? 1 : h;
            n_img = $urandom_range(1, 2);
            set_idle(grp % 4);
            write_reg(CFG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
            write_reg(CFG_IMAGE_HEIGHT, 16'(h));
            repeat (n_img) push_pixels(ew * eh, $urandom_range(3));
            rand_px += n_img * ew * eh;
            drain();
            grp++;
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/fsd_pkg.sv
hdl/fsd_line_mem.sv
hdl/fsd_diffuse.sv
hdl/floyd_steinberg_dither_1bit.sv
hdl/fsd_checker.sv
sim/floyd_steinberg_dither_1bit_tb.sv
